### hdl/sbom_pkg.sv
// ----------------------------------------------------------------------------
// sbom_pkg
// Shared types, codes and window helpers for the breakpoint overlap matcher.
// ----------------------------------------------------------------------------
package sbom_pkg;

   localparam int POS_W  = 31;
   localparam int WIN_W  = 32;
   localparam int TOL_W  = 20;
   localparam int CHR_W  = 8;
   localparam int FUNC_W = 2;
   localparam int STAT_W = 2;
   localparam int MASK_W = 4;

   localparam logic [FUNC_W-1:0] FUNC_LOAD    = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_COMPARE = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_READ    = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR   = 2'd3;

   localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
   localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_READ
   } state_type;

   typedef struct packed {
      logic [WIN_W-1:0] lo;
      logic [WIN_W-1:0] hi;
   } win_type;

   typedef struct packed {
      logic             kind;
      logic [CHR_W-1:0] chrom_b;
      logic [CHR_W-1:0] chrom_a;
      logic [POS_W-1:0] start_a;
      logic [POS_W-1:0] end_a;
      logic [POS_W-1:0] start_b;
      logic [POS_W-1:0] end_b;
   } rec_type;

   typedef struct packed {
      logic              region;
      logic [MASK_W-1:0] mask;
   } hit_type;

   // Record side of a compare: chromosomes and flags that travel with windows.
   typedef struct packed {
      logic             kind;
      logic [CHR_W-1:0] chrom_a;
      logic [CHR_W-1:0] chrom_b;
      logic             neq_a;
      logic             neq_b;
   } side_type;

   function automatic logic spans_meet(input win_type a, input win_type b);
      return (a.lo >= b.lo && a.lo <= b.hi) || (b.hi >= a.lo && b.hi <= a.hi) ||
             (b.lo >= a.lo && b.lo <= a.hi) || (a.hi >= b.lo && a.hi <= b.hi);
   endfunction

endpackage

### hdl/sbom_win_cell.sv
// ----------------------------------------------------------------------------
// sbom_win_cell
// Registered tolerance window of one position, clamped below at 1.
// ----------------------------------------------------------------------------
module sbom_win_cell
   import sbom_pkg::*;
(
   input  logic             clock,
   input  logic             load,
   input  logic [POS_W-1:0] pos,
   input  logic [TOL_W-1:0] tol,
   output win_type          win
);

   win_type win_ff, win_in;
   logic [WIN_W-1:0] pos_w, tol_w;

   always_comb begin
      pos_w = WIN_W'(pos);
      tol_w = WIN_W'(tol);
      win_in.lo = (pos_w > tol_w) ? pos_w - tol_w : WIN_W'(1);
      win_in.hi = pos_w + tol_w;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         win_ff <= win_in;
      end
   end

   assign win = win_ff;

endmodule

### hdl/sbom_match.sv
// ----------------------------------------------------------------------------
// sbom_match
// Overlap decision of one user record against one stored record.
// ----------------------------------------------------------------------------
module sbom_match
   import sbom_pkg::*;
(
   input  side_type usr,
   input  win_type  usr_win [4],
   input  side_type ben,
   input  win_type  ben_win [4],
   output hit_type  usr_hit,
   output hit_type  ben_hit
);

   // 0 none, 1 stored first end, 2 stored second end
   function automatic logic [1:0] end_hit(input win_type u, input win_type s,
                                          input win_type e, input logic neq);
      if (spans_meet(u, s)) begin
         return 2'd1;
      end
      if (neq && spans_meet(u, e)) begin
         return 2'd2;
      end
      return 2'd0;
   endfunction

   win_type     reg_win;
   logic        hit_first, hit_second;
   logic        sel_a [2];
   logic        sel_b [2];
   logic        ok    [2];
   logic [1:0]  r_s   [2];
   logic [1:0]  r_e   [2];
   logic [CHR_W-1:0] uc [2];
   logic        uneq  [2];

   always_comb begin
      reg_win.lo = usr_win[0].lo;
      reg_win.hi = usr_win[1].hi;
      usr_hit = '0;
      ben_hit = '0;
      hit_first  = usr.chrom_a != '0 && usr.chrom_a == ben.chrom_a &&
                   spans_meet(reg_win, '{lo: ben_win[0].lo, hi: ben_win[1].hi});
      hit_second = !hit_first && ben.kind && usr.chrom_a != '0 &&
                   usr.chrom_a == ben.chrom_b &&
                   spans_meet(reg_win, '{lo: ben_win[2].lo, hi: ben_win[3].hi});
      uc[0] = usr.chrom_a;  uneq[0] = usr.neq_a;
      uc[1] = usr.chrom_b;  uneq[1] = usr.neq_b;
      for (int k = 0; k < 2; k++) begin
         sel_a[k] = uc[k] == ben.chrom_a;
         sel_b[k] = !sel_a[k] && uc[k] == ben.chrom_b;
         ok[k]    = uc[k] != '0 && (sel_a[k] || sel_b[k]);
         if (sel_a[k]) begin
            r_s[k] = end_hit(usr_win[2*k], ben_win[0], ben_win[1], ben.neq_a);
            r_e[k] = end_hit(usr_win[2*k+1], ben_win[0], ben_win[1], ben.neq_a);
         end else begin
            r_s[k] = end_hit(usr_win[2*k], ben_win[2], ben_win[3], ben.neq_b);
            r_e[k] = end_hit(usr_win[2*k+1], ben_win[2], ben_win[3], ben.neq_b);
         end
         if (!ok[k]) begin
            r_s[k] = 2'd0;
         end
         if (!ok[k] || !uneq[k]) begin
            r_e[k] = 2'd0;
         end
      end
      if (!usr.kind) begin
         usr_hit.region = hit_first || hit_second;
         ben_hit.region = hit_first || hit_second;
      end else begin
         for (int k = 0; k < 2; k++) begin
            usr_hit.mask[2*k]   = r_s[k] != 2'd0;
            usr_hit.mask[2*k+1] = r_e[k] != 2'd0;
            if (sel_a[k]) begin
               ben_hit.mask[0] = ben_hit.mask[0] | r_s[k] == 2'd1 | r_e[k] == 2'd1;
               ben_hit.mask[1] = ben_hit.mask[1] | r_s[k] == 2'd2 | r_e[k] == 2'd2;
            end else begin
               ben_hit.mask[2] = ben_hit.mask[2] | r_s[k] == 2'd1 | r_e[k] == 2'd1;
               ben_hit.mask[3] = ben_hit.mask[3] | r_s[k] == 2'd2 | r_e[k] == 2'd2;
            end
         end
      end
   end

endmodule

### hdl/sv_breakpoint_overlap_matcher.sv
// ----------------------------------------------------------------------------
// sv_breakpoint_overlap_matcher
// Benchmark variant table with tolerance-window overlap matching.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken when start is high and busy is low. Every request
//   yields exactly one response, shown for one cycle with rsp_valid high;
//   the receiver cannot stall it.
//   Load and clear: response in the cycle after the request, busy stays low, so
//   these may be issued back to back.
//   Readback: the flag memory is read, then the response is registered; when
//   the index is beyond the count, the response follows in the next cycle.
//   Compare: the table is walked one entry per cycle through a read stage, a
//   row of window cells and the match stage; the response is registered once
//   the last entry has passed the match stage (in the cycle after the request
//   when the table is empty). One record read per cycle sets that rate; the
//   flag memory is read one entry ahead of the write-back, so it has one
//   read and one write port.
//   csr_* writes the tolerance; csr_ready is always high, write only idle.
//   Reset empties the table (count zero) and sets the tolerance to 100.
//   Flags of an entry are zeroed when it is loaded, so no clearing pass runs.
// ----------------------------------------------------------------------------
module sv_breakpoint_overlap_matcher
   import sbom_pkg::*;
#(
   parameter int TABLE_DEPTH = 1024,
   localparam int CW = $clog2(TABLE_DEPTH + 1),
   localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [FUNC_W-1:0] req_func,
   input  logic              req_is_breakpoint_type,
   input  logic [CHR_W-1:0]  req_chrom_a,
   input  logic [CHR_W-1:0]  req_chrom_b,
   input  logic [POS_W-1:0]  req_start_a,
   input  logic [POS_W-1:0]  req_end_a,
   input  logic [POS_W-1:0]  req_start_b,
   input  logic [POS_W-1:0]  req_end_b,
   input  logic [9:0]        req_entry_index,
   output logic              rsp_valid,
   output logic              rsp_region_hit,
   output logic [MASK_W-1:0] rsp_bp_flags,
   output logic [STAT_W-1:0] rsp_status,
   output logic [CW-1:0]     rsp_entry_count,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [TOL_W-1:0]  csr_data
);

   state_type state_ff, state_in;
   logic [TOL_W-1:0] tol_ff;
   logic [CW-1:0]    count_ff, count_in;
   logic [IW-1:0]    scan_ff, scan_in;

   // response register
   logic              rv_ff, rv_in;
   hit_type           rh_ff, rh_in;
   logic [STAT_W-1:0] rs_ff, rs_in;
   logic [CW-1:0]     rc_ff, rc_in;

   // compare accumulators and user side
   hit_type  acc_ff, acc_in;
   side_type usr_ff;

   // memories
   rec_type mem_rec  [TABLE_DEPTH];
   hit_type mem_flag [TABLE_DEPTH];
   rec_type rec_rd_ff;
   hit_type flag_rd_ff;
   logic          rec_re;
   logic [IW-1:0] rec_ra;
   logic          rec_we;
   logic          flag_we, flag_re;
   logic [IW-1:0] flag_wa, flag_ra;
   hit_type       flag_wd;

   // pipeline tags
   logic          v1_ff, last1_ff, v2_ff, last2_ff;
   logic [IW-1:0] idx1_ff, idx2_ff;
   side_type      ben2_ff;

   logic          accept, last_issue;
   logic [31:0]   idx_ext;
   rec_type       req_rec;
   win_type       usr_win [4];
   win_type       ben_win [4];
   logic [POS_W-1:0] usr_pos [4];
   logic [POS_W-1:0] ben_pos [4];
   hit_type       usr_hit, ben_hit;

   assign accept    = start && !busy;
   assign busy      = state_ff != ST_IDLE;
   assign csr_ready = 1'b1;
   assign idx_ext   = 32'(req_entry_index);
   assign last_issue = CW'(scan_ff) == count_ff - CW'(1);

   assign req_rec = '{kind: req_is_breakpoint_type, chrom_b: req_chrom_b,
                      chrom_a: req_chrom_a, start_a: req_start_a, end_a: req_end_a,
                      start_b: req_start_b, end_b: req_end_b};

   // window cells: four for the user record, four for the stored record
   assign usr_pos[0] = req_start_a;
   assign usr_pos[1] = req_end_a;
   assign usr_pos[2] = req_start_b;
   assign usr_pos[3] = req_end_b;
   assign ben_pos[0] = rec_rd_ff.start_a;
   assign ben_pos[1] = rec_rd_ff.end_a;
   assign ben_pos[2] = rec_rd_ff.start_b;
   assign ben_pos[3] = rec_rd_ff.end_b;

   for (genvar g = 0; g < 4; g++) begin : g_cells
      sbom_win_cell u_usr (.clock(clock), .load(accept), .pos(usr_pos[g]),
                           .tol(tol_ff), .win(usr_win[g]));
      sbom_win_cell u_ben (.clock(clock), .load(v1_ff), .pos(ben_pos[g]),
                           .tol(tol_ff), .win(ben_win[g]));
   end

   sbom_match u_match (
      .usr(usr_ff), .usr_win(usr_win), .ben(ben2_ff), .ben_win(ben_win),
      .usr_hit(usr_hit), .ben_hit(ben_hit)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         tol_ff   <= TOL_W'(100);
         count_ff <= '0;
         rv_ff    <= 1'b0;
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rv_ff    <= rv_in;
         v1_ff    <= state_ff == ST_SCAN;
         v2_ff    <= v1_ff;
         if (csr_valid && csr_ready) begin
            tol_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      scan_ff  <= scan_in;
      acc_ff   <= acc_in;
      rh_ff    <= rh_in;
      rs_ff    <= rs_in;
      rc_ff    <= rc_in;
      idx1_ff  <= scan_ff;
      last1_ff <= last_issue;
      idx2_ff  <= idx1_ff;
      last2_ff <= last1_ff;
      ben2_ff  <= '{kind: rec_rd_ff.kind, chrom_a: rec_rd_ff.chrom_a,
                    chrom_b: rec_rd_ff.chrom_b,
                    neq_a: rec_rd_ff.start_a != rec_rd_ff.end_a,
                    neq_b: rec_rd_ff.start_b != rec_rd_ff.end_b};
      if (accept) begin
         usr_ff <= '{kind: req_is_breakpoint_type, chrom_a: req_chrom_a,
                     chrom_b: req_chrom_b, neq_a: req_start_a != req_end_a,
                     neq_b: req_start_b != req_end_b};
      end
   end

   // record memory
   always_ff @(posedge clock) begin
      if (rec_we) begin
         mem_rec[count_ff[IW-1:0]] <= req_rec;
      end
      if (rec_re) begin
         rec_rd_ff <= mem_rec[rec_ra];
      end
   end

   // flag memory
   always_ff @(posedge clock) begin
      if (flag_we) begin
         mem_flag[flag_wa] <= flag_wd;
      end
      if (flag_re) begin
         flag_rd_ff <= mem_flag[flag_ra];
      end
   end

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      scan_in  = scan_ff;
      acc_in   = acc_ff;
      rv_in    = 1'b0;
      rh_in    = '0;
      rs_in    = STAT_OK;
      rc_in    = count_ff;
      rec_we   = 1'b0;
      rec_re   = 1'b0;
      rec_ra   = scan_ff;
      flag_we  = 1'b0;
      flag_wa  = idx2_ff;
      flag_wd  = flag_rd_ff | ben_hit;
      flag_re  = v1_ff;
      flag_ra  = idx1_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_func)
                  FUNC_LOAD: begin
                     rv_in = 1'b1;
                     if (count_ff < CW'(TABLE_DEPTH)) begin
                        rec_we   = 1'b1;
                        flag_we  = 1'b1;
                        flag_wa  = count_ff[IW-1:0];
                        flag_wd  = '0;
                        count_in = count_ff + CW'(1);
                        rc_in    = count_ff + CW'(1);
                     end else begin
                        rs_in = STAT_FULL;
                     end
                  end
                  FUNC_COMPARE: begin
                     if (count_ff == '0) begin
                        rv_in = 1'b1;
                     end else begin
                        state_in = ST_SCAN;
                        scan_in  = '0;
                        acc_in   = '0;
                     end
                  end
                  FUNC_READ: begin
                     if (idx_ext < 32'(count_ff)) begin
                        flag_re  = 1'b1;
                        flag_ra  = idx_ext[IW-1:0];
                        state_in = ST_READ;
                     end else begin
                        rv_in = 1'b1;
                        rs_in = STAT_RANGE;
                     end
                  end
                  default: begin
                     rv_in    = 1'b1;
                     count_in = '0;
                     rc_in    = '0;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            rec_re  = 1'b1;
            scan_in = scan_ff + IW'(1);
            if (last_issue) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
         end
         ST_READ: begin
            rv_in    = 1'b1;
            rh_in    = flag_rd_ff;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // match stage writeback
      if (v2_ff) begin
         flag_we = 1'b1;
         flag_wa = idx2_ff;
         flag_wd = flag_rd_ff | ben_hit;
         acc_in  = acc_ff | usr_hit;
         if (last2_ff) begin
            rv_in    = 1'b1;
            rh_in    = acc_ff | usr_hit;
            state_in = ST_IDLE;
         end
      end
   end

   assign rsp_valid       = rv_ff;
   assign rsp_region_hit  = rh_ff.region;
   assign rsp_bp_flags    = rh_ff.mask;
   assign rsp_status      = rs_ff;
   assign rsp_entry_count = rc_ff;

endmodule

### hdl/sbom_checker.sv
// ----------------------------------------------------------------------------
// sbom_checker
// Port-level checks of the breakpoint overlap matcher.
// ----------------------------------------------------------------------------
module sbom_checker
   import sbom_pkg::*;
#(
   parameter int TABLE_DEPTH = 1024,
   localparam int CW = $clog2(TABLE_DEPTH + 1)
)
(
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic [FUNC_W-1:0] req_func,
   input logic              rsp_valid,
   input logic              rsp_region_hit,
   input logic [MASK_W-1:0] rsp_bp_flags,
   input logic [STAT_W-1:0] rsp_status,
   input logic [CW-1:0]     rsp_entry_count
);

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response after reset");

   a_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STAT_FULL |-> rsp_entry_count == CW'(TABLE_DEPTH))
      else $error("full status with room left");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STAT_RANGE |-> !rsp_region_hit && rsp_bp_flags == '0)
      else $error("flags on out of range readback");

   a_clear: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_func == FUNC_CLEAR |=> rsp_valid && rsp_entry_count == '0)
      else $error("clear did not empty the table");

endmodule

bind sv_breakpoint_overlap_matcher sbom_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_sbom_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy), .req_func(req_func),
   .rsp_valid(rsp_valid), .rsp_region_hit(rsp_region_hit),
   .rsp_bp_flags(rsp_bp_flags), .rsp_status(rsp_status),
   .rsp_entry_count(rsp_entry_count)
);
